[hw/rtl/htc_pkg.sv]
// Shared constants, codes and helpers for the code-table codec.
// No dependencies; used by htc_table and huffman_table_codec_core.
package htc_pkg;

    localparam int SYMBOLS_DEF      = 256;
    localparam int MAX_CODE_LEN_DEF = 16;

    // Width of the length fields on the ports (0..16)
    localparam int LEN_W  = 5;
    // Code word field width on the ports
    localparam int WORD_W = 16;
    localparam int SYM_FIELD_W = 8;

    // Request modes (tuser on the input side)
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ENC  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;

    // Result kinds (tuser on the output side)
    localparam logic [1:0] KIND_CODE = 2'd0;
    localparam logic [1:0] KIND_SYM  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Low len bits set
    function automatic logic [WORD_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [WORD_W-1:0] m;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = (LEN_W'(i) < len);
        end
        return m;
    endfunction

endpackage

[hw/rtl/htc_table.sv]
// Code table memory: one entry per symbol, code plus length, with
// per-entry valid bits so unwritten entries read as absent. Uses htc_pkg.
module htc_table #(
    parameter int SYMBOLS = htc_pkg::SYMBOLS_DEF,
    parameter int CODE_W  = htc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [$clog2(SYMBOLS)-1:0] i_wr_addr,
    input  logic [CODE_W-1:0]          i_wr_code,
    input  logic [htc_pkg::LEN_W-1:0]  i_wr_len,
    input  logic [$clog2(SYMBOLS)-1:0] i_rd_addr,
    output logic [CODE_W-1:0]          o_rd_code,
    output logic [htc_pkg::LEN_W-1:0]  o_rd_len
);

    localparam int ENT_W = CODE_W + htc_pkg::LEN_W;

    logic [ENT_W-1:0]   mem [SYMBOLS];
    logic [SYMBOLS-1:0] r_vld;
    logic [ENT_W-1:0]   r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_len, i_wr_code};
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // Entry never written reads as length zero, code zero
    assign o_rd_code = r_rd_vld ? r_rd_data[CODE_W-1:0] : '0;
    assign o_rd_len  = r_rd_vld ? r_rd_data[ENT_W-1:CODE_W] : '0;

endmodule

[hw/rtl/huffman_table_codec_core.sv]
// Top level of the code-table codec: request decode, table scan sequencer,
// accumulator and output register. Uses htc_pkg and htc_table.
//
//  channel   dir  tdata                                         tuser
//  s_axis    in   symbol, load_code, load_len, bit_in          mode
//  m_axis    out  code_word, code_length, decoded_symbol       kind
//
// Load: table write, no result. Encode: table read, result, hand-off.
// Decode bit: a table scan through the single read port, one entry per cycle,
// ending early at the first match; no result while the accumulated bits
// match no entry and are still shorter than the code length limit.
// Reset clears state, valid bits and the accumulator; no clearing pass.
// A finished result sits in the output register while the next request is
// taken; a new result waits until that register is free.
module huffman_table_codec_core #(
    parameter int SYMBOLS      = htc_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = htc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] symbol, [23:8] load_code, [28:24] load_len, [29] bit_in, [31:30] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] code_word, [20:16] code_length, [28:21] decoded_symbol, [31:29] zero
    output logic [31:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]  m_axis_tuser
);

    localparam int LEN_W  = htc_pkg::LEN_W;
    localparam int CODE_W = (MAX_CODE_LEN < htc_pkg::WORD_W) ? MAX_CODE_LEN
                                                              : htc_pkg::WORD_W;
    localparam int SYM_W  = $clog2(SYMBOLS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ENC  = 4'b0010,
        S_DEC  = 4'b0100,
        S_RES  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CODE_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0]  r_alen, n_alen;
    logic [CODE_W-1:0] r_cand_acc, n_cand_acc;
    logic [LEN_W-1:0]  r_cand_len, n_cand_len;
    logic [SYM_W-1:0]  r_scan, n_scan;

    logic [1:0]        r_res_kind, n_res_kind;
    logic [15:0]       r_res_word, n_res_word;
    logic [LEN_W-1:0]  r_res_len, n_res_len;
    logic [7:0]        r_res_sym, n_res_sym;

    logic              r_ovld;
    logic [31:0]       r_otdata;
    logic [1:0]        r_otuser;

    logic [7:0]        in_sym;
    logic [15:0]       in_code;
    logic [LEN_W-1:0]  in_len;
    logic              in_bit;
    logic              s_accept;
    logic              sym_ok;
    logic              len_ok;
    logic              slot_free;
    logic              hit;

    logic              wr_en;
    logic [CODE_W-1:0] wr_code;
    logic [LEN_W-1:0]  wr_len;
    logic [SYM_W-1:0]  rd_addr;
    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;

    assign in_sym  = s_axis_tdata[7:0];
    assign in_code = s_axis_tdata[23:8];
    assign in_len  = s_axis_tdata[28:24];
    assign in_bit  = s_axis_tdata[29];

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign sym_ok        = ({1'b0, in_sym} < 9'(SYMBOLS));
    assign len_ok        = (in_len != '0) && (in_len <= LEN_W'(CODE_W));
    assign slot_free     = !r_ovld || m_axis_tready;

    // Overlong or zero length stores an absent entry
    assign wr_len  = len_ok ? in_len : '0;
    assign wr_code = len_ok ? (in_code[CODE_W-1:0] & CODE_W'(htc_pkg::len_mask(in_len)))
                            : '0;

    // Candidate length is never zero, so absent entries cannot match
    assign hit = (rd_len == r_cand_len) && (rd_code == r_cand_acc);

    htc_table #(
        .SYMBOLS (SYMBOLS),
        .CODE_W  (CODE_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (in_sym[SYM_W-1:0]),
        .i_wr_code (wr_code),
        .i_wr_len  (wr_len),
        .i_rd_addr (rd_addr),
        .o_rd_code (rd_code),
        .o_rd_len  (rd_len)
    );

    always_comb begin
        n_state    = r_state;
        n_acc      = r_acc;
        n_alen     = r_alen;
        n_cand_acc = r_cand_acc;
        n_cand_len = r_cand_len;
        n_scan     = r_scan;
        n_res_kind = r_res_kind;
        n_res_word = r_res_word;
        n_res_len  = r_res_len;
        n_res_sym  = r_res_sym;
        wr_en      = 1'b0;
        rd_addr    = SYM_W'(r_scan + 1'b1);

        unique case (r_state)
            S_IDLE: begin
                rd_addr = in_sym[SYM_W-1:0];
                if (s_accept) begin
                    unique case (s_axis_tuser)
                        htc_pkg::MODE_LOAD: begin
                            wr_en = sym_ok;
                        end
                        htc_pkg::MODE_ENC: begin
                            if (sym_ok) begin
                                n_state = S_ENC;
                            end else begin
                                n_res_kind = htc_pkg::KIND_ERR;
                                n_res_word = '0;
                                n_res_len  = '0;
                                n_res_sym  = '0;
                                n_state    = S_RES;
                            end
                        end
                        htc_pkg::MODE_DEC: begin
                            rd_addr    = '0;
                            n_scan     = '0;
                            n_cand_acc = CODE_W'({r_acc, in_bit});
                            n_cand_len = LEN_W'(r_alen + 1'b1);
                            n_state    = S_DEC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ENC: begin
                n_res_sym = '0;
                if (rd_len == '0) begin
                    n_res_kind = htc_pkg::KIND_ERR;
                    n_res_word = '0;
                    n_res_len  = '0;
                end else begin
                    n_res_kind = htc_pkg::KIND_CODE;
                    n_res_word = 16'(rd_code);
                    n_res_len  = rd_len;
                end
                n_state = S_RES;
            end
            S_DEC: begin
                // rd data holds entry r_scan; next entry is being read
                n_scan = SYM_W'(r_scan + 1'b1);
                if (hit) begin
                    n_acc      = '0;
                    n_alen     = '0;
                    n_res_kind = htc_pkg::KIND_SYM;
                    n_res_word = '0;
                    n_res_len  = '0;
                    n_res_sym  = 8'(r_scan);
                    n_state    = S_RES;
                end else if (r_scan == SYM_W'(SYMBOLS - 1)) begin
                    if (r_cand_len >= LEN_W'(CODE_W)) begin
                        n_acc      = '0;
                        n_alen     = '0;
                        n_res_kind = htc_pkg::KIND_ERR;
                        n_res_word = '0;
                        n_res_len  = '0;
                        n_res_sym  = '0;
                        n_state    = S_RES;
                    end else begin
                        n_acc   = r_cand_acc;
                        n_alen  = r_cand_len;
                        n_state = S_IDLE;
                    end
                end
            end
            S_RES: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_alen  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_alen  <= n_alen;
            if (r_state == S_RES && slot_free) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand_acc <= n_cand_acc;
        r_cand_len <= n_cand_len;
        r_scan     <= n_scan;
        r_res_kind <= n_res_kind;
        r_res_word <= n_res_word;
        r_res_len  <= n_res_len;
        r_res_sym  <= n_res_sym;
        if (r_state == S_RES && slot_free) begin
            r_otdata <= {3'b000, r_res_sym, r_res_len, r_res_word};
            r_otuser <= r_res_kind;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_otdata;
    assign m_axis_tuser  = r_otuser;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for huffman_table_codec_core: table loads, symbol
// encodes and bitwise decodes, checked against an in-bench code-table predictor.
// Depends on htc_pkg and the codec RTL.
module tb_top;

    localparam int SYMBOLS      = 256;
    localparam int MAX_CODE_LEN = 16;
    localparam int CODE_LIMIT   = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
    localparam int ITEM_TARGET  = 1750;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 2 * SYMBOLS + 40;
    localparam logic [1:0] MODE_LOAD = htc_pkg::MODE_LOAD;
    localparam logic [1:0] MODE_ENC  = htc_pkg::MODE_ENC;
    localparam logic [1:0] MODE_DEC  = htc_pkg::MODE_DEC;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [1:0] KIND_CODE = htc_pkg::KIND_CODE;
    localparam logic [1:0] KIND_SYM  = htc_pkg::KIND_SYM;
    localparam logic [1:0] KIND_ERR  = htc_pkg::KIND_ERR;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  symbol;
        logic [15:0] load_code;
        logic [4:0]  load_len;
        logic        bit_in;
        bit          hold;      // sender drains all results before this request
    } t_codec_req;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] word;
        logic [4:0]  length;
        logic [7:0]  sym;
    } t_codec_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] symbol, [23:8] load_code, [28:24] load_len, [29] bit_in, [31:30] zero
    logic [31:0] s_axis_tdata = '0;
    // [1:0] mode
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] code_word, [20:16] code_length, [28:21] decoded_symbol, [31:29] zero
    logic [31:0] m_axis_tdata;
    // [1:0] kind
    logic [1:0]  m_axis_tuser;

    // predictor state
    logic [15:0] tbl_code [SYMBOLS];
    logic [4:0]  tbl_len  [SYMBOLS];
    logic [15:0] acc_bits = '0;
    logic [4:0]  acc_len = '0;

    t_codec_req  request_q [$];
    t_codec_res  codec_results_q [$];
    t_codec_req  cur_req;
    bit          have_req = 1'b0;
    bit          req_taken = 1'b0;
    bit          hold_next = 1'b0;
    int          gen_len [SYMBOLS];
    int          cycle_cnt = 0;
    int          sent_cnt = 0;
    int          stim_cnt = 0;
    int          err_cnt = 0;

    huffman_table_codec_core #(
        .SYMBOLS      (SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h, wanted 0x%0h",
                 cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // Applies one accepted request to the table/accumulator copy and queues
    // the result it should produce, if any.
    task automatic codec_step(input t_codec_req r);
        logic [15:0] nxt_bits;
        int          nxt_len;
        int          hit;
        t_codec_res  res;
        res.kind   = KIND_ERR;
        res.word   = '0;
        res.length = '0;
        res.sym    = '0;
        case (r.mode)
            MODE_LOAD: begin
                if (r.symbol < SYMBOLS) begin
                    if (r.load_len == 0 || r.load_len > CODE_LIMIT) begin
                        tbl_len[r.symbol]  = '0;
                        tbl_code[r.symbol] = '0;
                    end else begin
                        tbl_len[r.symbol]  = r.load_len;
                        tbl_code[r.symbol] = r.load_code & 16'((32'd1 << r.load_len) - 1);
                    end
                end
            end
            MODE_ENC: begin
                if (r.symbol < SYMBOLS && tbl_len[r.symbol] != 0) begin
                    res.kind   = KIND_CODE;
                    res.word   = tbl_code[r.symbol];
                    res.length = tbl_len[r.symbol];
                end
                codec_results_q.push_back(res);
            end
            MODE_DEC: begin
                nxt_bits = {acc_bits[14:0], r.bit_in};
                nxt_len  = acc_len + 1;
                hit      = -1;
                // scan downward so the lowest matching symbol is kept
                for (int j = SYMBOLS - 1; j >= 0; j--) begin
                    if (tbl_len[j] != 0 && tbl_len[j] == nxt_len && tbl_code[j] == nxt_bits)
                        hit = j;
                end
                if (hit >= 0) begin
                    res.kind = KIND_SYM;
                    res.sym  = 8'(hit);
                end
                if (hit >= 0 || nxt_len >= CODE_LIMIT) begin
                    acc_bits = '0;
                    acc_len  = '0;
                    codec_results_q.push_back(res);
                end else begin
                    acc_bits = nxt_bits;
                    acc_len  = 5'(nxt_len);
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_request(input logic [1:0] mode, input logic [7:0] sym,
                                 input logic [15:0] code, input logic [4:0] len,
                                 input logic b);
        t_codec_req r;
        r.mode      = mode;
        r.symbol    = sym;
        r.load_code = code;
        r.load_len  = len;
        r.bit_in    = b;
        r.hold      = hold_next;
        hold_next   = 1'b0;
        request_q.push_back(r);
        if (mode != MODE_NONE)
            stim_cnt++;
        if (mode == MODE_LOAD)
            gen_len[sym] = (len > CODE_LIMIT) ? 0 : int'(len);
    endtask

    // Driver: presents requests at the falling edge.
    always @(negedge i_clk) begin
        bit calm;
        calm = (sent_cnt >= 700 && sent_cnt < 1000);
        if (req_taken) begin
            have_req  = 1'b0;
            req_taken = 1'b0;
        end
        if (i_rst_n && !have_req && request_q.size() != 0) begin
            if (!(request_q[0].hold && codec_results_q.size() != 0) &&
                (calm || $urandom_range(99) >= 27)) begin
                cur_req  = request_q.pop_front();
                have_req = 1'b1;
            end
        end
        s_axis_tvalid <= have_req;
        s_axis_tdata  <= {2'b00, cur_req.bit_in, cur_req.load_len, cur_req.load_code,
                          cur_req.symbol};
        s_axis_tuser  <= cur_req.mode;
        m_axis_tready <= calm || ($urandom_range(99) >= 27);
    end

    // Monitor: samples both handshakes at the rising edge.
    always @(posedge i_clk) begin
        t_codec_res want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (codec_results_q.size() == 0) begin
                    report_mismatch("result with none pending, kind", 32'(m_axis_tuser), '0);
                end else begin
                    want = codec_results_q.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
                    if (m_axis_tdata[15:0] !== want.word)
                        report_mismatch("code_word", 32'(m_axis_tdata[15:0]), 32'(want.word));
                    if (m_axis_tdata[20:16] !== want.length)
                        report_mismatch("code_length", 32'(m_axis_tdata[20:16]),
                                        32'(want.length));
                    if (m_axis_tdata[28:21] !== want.sym)
                        report_mismatch("decoded_symbol", 32'(m_axis_tdata[28:21]),
                                        32'(want.sym));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                codec_step(cur_req);
                req_taken = 1'b1;
                sent_cnt++;
            end
        end
    end

    initial begin
        logic [15:0] leaf_code [64];
        int          leaf_len [64];
        logic [7:0]  perm [SYMBOLS];
        bit          in_set [SYMBOLS];
        logic [7:0]  tmp;
        int          nleaf, target, k, tries, nops, phase, pick, sel, cut;
        bit          deep, keep_old;

        cur_req.mode      = MODE_LOAD;
        cur_req.symbol    = '0;
        cur_req.load_code = '0;
        cur_req.load_len  = '0;
        cur_req.bit_in    = 1'b0;
        cur_req.hold      = 1'b0;
        for (int i = 0; i < SYMBOLS; i++) begin
            tbl_code[i] = '0;
            tbl_len[i]  = '0;
            gen_len[i]  = 0;
        end

        // directed requests
        queue_request(MODE_ENC, 8'd0, 16'd0, 5'd0, 1'b0);          // empty table
        queue_request(MODE_LOAD, 8'd0, 16'hFFFE, 5'd1, 1'b0);      // upper bits dropped
        queue_request(MODE_ENC, 8'd0, 16'd0, 5'd0, 1'b0);
        queue_request(MODE_LOAD, 8'd255, 16'h7FFF, 5'd16, 1'b1);   // longest code
        queue_request(MODE_ENC, 8'd255, 16'hFFFF, 5'd31, 1'b1);
        queue_request(MODE_LOAD, 8'd7, 16'hFFFF, 5'd31, 1'b1);     // too long: absent
        queue_request(MODE_ENC, 8'd7, 16'd0, 5'd0, 1'b0);
        queue_request(MODE_LOAD, 8'd3, 16'h0000, 5'd1, 1'b0);      // same code as 0
        queue_request(MODE_DEC, 8'hFF, 16'hFFFF, 5'h1F, 1'b0);     // 0 beats 3
        queue_request(MODE_NONE, 8'hFF, 16'hFFFF, 5'h1F, 1'b1);    // unused mode
        queue_request(MODE_LOAD, 8'd0, 16'h0000, 5'd0, 1'b0);
        queue_request(MODE_DEC, 8'd0, 16'd0, 5'd0, 1'b0);          // now 3
        // all ones never match: overflow on the sixteenth bit
        for (int i = 0; i < 16; i++)
            queue_request(MODE_DEC, 8'd0, 16'd0, 5'd0, 1'b1);

        // random phases: fresh prefix code, then encodes, code-word streams and other random requests
        phase = 0;
        while (stim_cnt < ITEM_TARGET) begin
            hold_next = (phase % 4 == 3);
            nleaf = 2;
            leaf_code[0] = 16'd0;
            leaf_len[0]  = 1;
            leaf_code[1] = 16'd1;
            leaf_len[1]  = 1;
            target = ($urandom_range(3) == 0) ? $urandom_range(24, 64) : $urandom_range(2, 16);
            deep   = 1'($urandom_range(1));
            tries  = 0;
            // split leaves; "deep" often picks the newest leaf to split, for long codes
            while (nleaf < target && tries < 1000) begin
                k = (deep && $urandom_range(1)) ? nleaf - 1 : $urandom_range(nleaf - 1);
                if (leaf_len[k] < CODE_LIMIT) begin
                    leaf_code[nleaf] = (leaf_code[k] << 1) | 16'd1;
                    leaf_len[nleaf]  = leaf_len[k] + 1;
                    leaf_code[k]     = leaf_code[k] << 1;
                    leaf_len[k]++;
                    nleaf++;
                end
                tries++;
            end

            for (int i = 0; i < SYMBOLS; i++)
                perm[i] = 8'(i);
            for (int i = SYMBOLS - 1; i > 0; i--) begin
                sel = $urandom_range(i);
                tmp = perm[i];
                perm[i] = perm[sel];
                perm[sel] = tmp;
            end
            for (int i = 0; i < SYMBOLS; i++)
                in_set[i] = 1'b0;
            for (int i = 0; i < nleaf; i++)
                in_set[perm[i]] = 1'b1;

            // now and then stale entries stay, leaving an ambiguous table
            keep_old = ($urandom_range(5) == 0);
            for (int i = 0; i < SYMBOLS; i++) begin
                if (!keep_old && !in_set[i] && gen_len[i] != 0)
                    queue_request(MODE_LOAD, 8'(i), 16'($urandom), 5'd0, 1'($urandom));
            end
            for (int i = 0; i < nleaf; i++)
                queue_request(MODE_LOAD, perm[i], leaf_code[i] | 16'($urandom << leaf_len[i]),
                              5'(leaf_len[i]), 1'($urandom));

            nops = $urandom_range(10, 40);
            for (int n = 0; n < nops; n++) begin
                pick = $urandom_range(99);
                sel  = $urandom_range(nleaf - 1);
                if (pick < 50 || pick >= 89) begin
                    // whole code word, or the head of one
                    cut = (pick < 50) ? 0 : $urandom_range(leaf_len[sel] - 1);
                    for (int b = leaf_len[sel] - 1; b >= cut; b--)
                        queue_request(MODE_DEC, 8'($urandom), 16'($urandom), 5'($urandom),
                                      leaf_code[sel][b]);
                end else if (pick < 70) begin
                    queue_request(MODE_ENC, (pick < 62) ? perm[sel] : 8'($urandom),
                                  16'($urandom), 5'($urandom), 1'($urandom));
                end else if (pick < 80) begin
                    queue_request(MODE_DEC, 8'($urandom), 16'($urandom), 5'($urandom),
                                  1'($urandom));
                end else if (pick < 85) begin
                    queue_request(MODE_NONE, 8'($urandom), 16'($urandom), 5'($urandom),
                                  1'($urandom));
                end else begin
                    queue_request(MODE_LOAD, 8'($urandom), 16'($urandom),
                                  5'($urandom_range(31)), 1'($urandom));
                end
            end
            phase++;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || have_req)
            @(posedge i_clk);
        while (codec_results_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
